>>> hdl/spimrb_pkg.sv
// Shared types and constants for the SPI master register block.
// Register offsets, control and status bit positions, and the item and result layouts.
// No dependencies.
`default_nettype none

package spimrb_pkg;

    localparam int CHANNELS_DEFAULT = 4;
    localparam int CS_SLOTS         = 4;
    localparam int CS_W             = 2;
    localparam int CFG_W            = 4;
    localparam int S_DATA_W         = 56;
    localparam int M_DATA_W         = 24;

    localparam logic [11:0] OFF_CTRL = 12'h000;
    localparam logic [11:0] OFF_CS   = 12'h004;
    localparam logic [11:0] OFF_STAT = 12'h008;
    localparam logic [11:0] OFF_DATA = 12'h00C;

    localparam logic [7:0] CTRL_MASK  = 8'hE5;
    localparam int         CTRL_SPE    = 0;
    localparam int         CTRL_ERRIE  = 5;
    localparam int         CTRL_RXNEIE = 6;
    localparam int         CTRL_TXEIE  = 7;

    localparam int STAT_OVR = 4;

    typedef enum logic
    {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef struct packed
    {
        logic [7:0]  reply_byte;
        logic [31:0] write_data;
        logic [11:0] reg_offset;
        action_t     action;
    } item_t;

    typedef struct packed
    {
        logic [CS_W-1:0] released_channel;
        logic            cs_release;
        logic [CS_W-1:0] xfer_channel;
        logic [7:0]      tx_byte;
        logic            xfer_valid;
        logic            irq_line;
        logic [7:0]      read_data;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/spimrb_core.sv
// Register file and access logic of the SPI master register block.
// Holds control, chip select, status, receive byte and attached mask; computes one result per access.
// Depends on spimrb_pkg.
`default_nettype none

module spimrb_core #(
    parameter int CHANNELS = spimrb_pkg::CHANNELS_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          accept,
    input  spimrb_pkg::item_t            item,
    input  wire                          cfg_valid,
    input  wire [spimrb_pkg::CFG_W-1:0]  cfg_data,
    output spimrb_pkg::result_t          result
);

    logic [CHANNELS-1:0]                attached_reg;
    logic [7:0]                         control_reg, control_next;
    logic [spimrb_pkg::CS_W-1:0]        select_reg, select_next;
    logic                               rxne_reg, rxne_next;
    logic                               txe_reg, txe_next;
    logic                               ovr_reg, ovr_next;
    logic [7:0]                         rx_byte_reg, rx_byte_next;
    logic [spimrb_pkg::CS_SLOTS-1:0]    attached_ext;

    genvar g;
    generate
        for (g = 0; g < spimrb_pkg::CS_SLOTS; g++)
        begin : g_ext
            if (g < CHANNELS)
            begin : g_on
                assign attached_ext[g] = attached_reg[g];
            end
            else
            begin : g_off
                assign attached_ext[g] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        logic [spimrb_pkg::CS_W-1:0] new_cs;
        new_cs       = item.write_data[spimrb_pkg::CS_W-1:0];
        control_next = control_reg;
        select_next  = select_reg;
        rxne_next    = rxne_reg;
        txe_next     = txe_reg;
        ovr_next     = ovr_reg;
        rx_byte_next = rx_byte_reg;
        result       = '0;
        if (item.action == spimrb_pkg::ACT_READ)
        begin
            unique case (item.reg_offset)
                spimrb_pkg::OFF_CTRL: result.read_data = control_reg;
                spimrb_pkg::OFF_CS:   result.read_data = {6'd0, select_reg};
                spimrb_pkg::OFF_STAT: result.read_data = {3'd0, ovr_reg, 2'd0, txe_reg, rxne_reg};
                spimrb_pkg::OFF_DATA:
                begin
                    result.read_data = rx_byte_reg;
                    txe_next         = 1'b1;
                    rxne_next        = 1'b0;
                end
                default: result.read_data = 8'd0;
            endcase
        end
        else
        begin
            unique case (item.reg_offset)
                spimrb_pkg::OFF_CTRL: control_next = item.write_data[7:0] & spimrb_pkg::CTRL_MASK;
                spimrb_pkg::OFF_CS:
                begin
                    if (new_cs != select_reg && attached_ext[select_reg])
                    begin
                        result.cs_release       = 1'b1;
                        result.released_channel = select_reg;
                    end
                    select_next = new_cs;
                end
                spimrb_pkg::OFF_STAT:
                begin
                    if (item.write_data[spimrb_pkg::STAT_OVR])
                    begin
                        ovr_next = 1'b0;
                    end
                end
                spimrb_pkg::OFF_DATA:
                begin
                    if (rxne_reg)
                    begin
                        ovr_next = 1'b1;
                    end
                    else
                    begin
                        if (attached_ext[select_reg])
                        begin
                            rx_byte_next        = item.reply_byte;
                            result.xfer_valid   = 1'b1;
                            result.tx_byte      = item.write_data[7:0];
                            result.xfer_channel = select_reg;
                        end
                        else
                        begin
                            rx_byte_next = item.write_data[7:0];
                        end
                        rxne_next = 1'b1;
                        txe_next  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        result.irq_line = control_next[spimrb_pkg::CTRL_SPE] &
            ((control_next[spimrb_pkg::CTRL_ERRIE] & ovr_next) |
             (control_next[spimrb_pkg::CTRL_RXNEIE] & rxne_next) |
             (control_next[spimrb_pkg::CTRL_TXEIE] & txe_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attached_reg <= '0;
            control_reg  <= '0;
            select_reg   <= '0;
            rxne_reg     <= 1'b0;
            txe_reg      <= 1'b1;
            ovr_reg      <= 1'b0;
            rx_byte_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                attached_reg <= cfg_data[CHANNELS-1:0];
            end
            if (accept)
            begin
                control_reg <= control_next;
                select_reg  <= select_next;
                rxne_reg    <= rxne_next;
                txe_reg     <= txe_next;
                ovr_reg     <= ovr_next;
                rx_byte_reg <= rx_byte_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.action == spimrb_pkg::ACT_WRITE &&
        item.reg_offset == spimrb_pkg::OFF_DATA && rxne_reg
        |=> ovr_reg && $stable(rx_byte_reg))
        else $error("data write with unread byte did not flag overrun");
    a_data_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.action == spimrb_pkg::ACT_READ &&
        item.reg_offset == spimrb_pkg::OFF_DATA
        |=> !rxne_reg && txe_reg)
        else $error("data read did not clear RXNE");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.action == spimrb_pkg::ACT_WRITE &&
        item.reg_offset == spimrb_pkg::OFF_DATA && !rxne_reg
        |=> rxne_reg)
        else $error("exchange did not set RXNE");
`endif

endmodule

`default_nettype wire

>>> hdl/spi_master_register_block.sv
// Top level of the SPI master register block: stream handshakes and the result register.
// Depends on spimrb_pkg and spimrb_core.
`default_nettype none

// One bus access arrives per slave-side transaction: s_tuser is the read/write
// flag and s_tdata carries offset, write data and the device reply byte. Each
// access produces exactly one result transaction on the master side, carrying
// read data, interrupt level, exchange and chip-select release information.
// Register state is updated at the edge that accepts the access, and the
// result is held in an output register, so it appears in the cycle after
// acceptance and an access can be taken every cycle unless the receiver
// stalls; then the result is held, and s_tready drops only while it cannot leave.
// The attached-device mask is written over the cfg channel, which is always
// ready; it should be written only while no access is in flight.
// Reset clears control, chip select, receive byte and mask, sets status to
// TXE only, and empties the result register.
module spi_master_register_block #(
    parameter int CHANNELS = spimrb_pkg::CHANNELS_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // reg_offset[11:0], write_data[43:12], reply_byte[51:44], zero fill
    input  wire [spimrb_pkg::S_DATA_W-1:0]     s_tdata,
    // action[0]
    input  wire                                s_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // read_data[7:0], irq_line[8], xfer_valid[9], tx_byte[17:10],
    // xfer_channel[19:18], cs_release[20], released_channel[22:21], zero fill
    output logic [spimrb_pkg::M_DATA_W-1:0]    m_tdata,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [spimrb_pkg::CFG_W-1:0]        cfg_data
);

    spimrb_pkg::item_t   item;
    spimrb_pkg::result_t result;
    spimrb_pkg::result_t result_reg;
    logic                valid_reg;
    logic                accept;

    assign item.action     = spimrb_pkg::action_t'(s_tuser);
    assign item.reg_offset = s_tdata[11:0];
    assign item.write_data = s_tdata[43:12];
    assign item.reply_byte = s_tdata[51:44];

    assign s_tready  = !valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {1'b0, result_reg};

    spimrb_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted access produced no result");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !accept)
        else $error("access accepted while a stalled result is held");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !s_tvalid |=> !m_tvalid)
        else $error("result delivered twice");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_spi_master_register_block.sv
// Self-checking testbench for spi_master_register_block: register accesses stream in,
// one result per access is predicted and compared field by field, under random stalls.
// Depends on spimrb_pkg and the spi_master_register_block RTL.
module tb_spi_master_register_block;
    timeunit 1ns;
    timeprecision 1ps;

    import spimrb_pkg::*;

    localparam int NUM_CHANNELS  = CHANNELS_DEFAULT;
    localparam int STAT_RXNE_BIT = 0;
    localparam int STAT_TXE_BIT  = 1;
    localparam int IDLE_PCT      = 19;
    localparam int PHASE_ITEMS   = 95;
    localparam int STALL_LIMIT   = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;

    // Model state of the register block.
    logic [7:0]       ctrl_reg;
    logic [CS_W-1:0]  cs_reg;
    logic [4:0]       status_reg;
    logic [7:0]       rx_reg;
    logic [CFG_W-1:0] dev_mask;

    item_t   access_queue[$];
    result_t expected_results[$];
    item_t   next_access;
    item_t   seen_access;
    result_t seen_result;
    result_t want_result;
    logic    access_taken = 1'b0;
    logic    idle_off = 1'b0;

    int unsigned accesses_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mask_writes = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    spi_master_register_block DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic channel_attached(input logic [CS_W-1:0] ch);
        return (int'(ch) < NUM_CHANNELS) && dev_mask[ch];
    endfunction

    function automatic result_t predict_access(input item_t acc);
        result_t         res;
        logic [CS_W-1:0] new_cs;
        res = '0;
        if (acc.action == ACT_READ)
        begin
            case (acc.reg_offset)
                OFF_CTRL: res.read_data = ctrl_reg & CTRL_MASK;
                OFF_CS:   res.read_data = 8'(cs_reg);
                OFF_STAT: res.read_data = 8'(status_reg);
                OFF_DATA:
                begin
                    res.read_data = rx_reg;
                    status_reg[STAT_TXE_BIT] = 1'b1;
                    status_reg[STAT_RXNE_BIT] = 1'b0;
                end
                default: ;
            endcase
        end
        else
        begin
            case (acc.reg_offset)
                OFF_CTRL: ctrl_reg = acc.write_data[7:0] & CTRL_MASK;
                OFF_CS:
                begin
                    new_cs = acc.write_data[CS_W-1:0];
                    if (new_cs != cs_reg && channel_attached(cs_reg))
                    begin
                        res.cs_release = 1'b1;
                        res.released_channel = cs_reg;
                    end
                    cs_reg = new_cs;
                end
                OFF_STAT:
                begin
                    if (acc.write_data[STAT_OVR])
                        status_reg[STAT_OVR] = 1'b0;
                end
                OFF_DATA:
                begin
                    if (status_reg[STAT_RXNE_BIT])
                        status_reg[STAT_OVR] = 1'b1;
                    else
                    begin
                        if (channel_attached(cs_reg))
                        begin
                            rx_reg = acc.reply_byte;
                            res.xfer_valid = 1'b1;
                            res.tx_byte = acc.write_data[7:0];
                            res.xfer_channel = cs_reg;
                        end
                        else
                            rx_reg = acc.write_data[7:0];
                        status_reg[STAT_RXNE_BIT] = 1'b1;
                        status_reg[STAT_TXE_BIT] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res.irq_line = ctrl_reg[CTRL_SPE] &&
                       ((ctrl_reg[CTRL_ERRIE] && status_reg[STAT_OVR]) ||
                        (ctrl_reg[CTRL_RXNEIE] && status_reg[STAT_RXNE_BIT]) ||
                        (ctrl_reg[CTRL_TXEIE] && status_reg[STAT_TXE_BIT]));
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Accesses are launched at the falling edge and held until a transaction takes them.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || access_taken)
            begin
                if (access_queue.size() != 0 && (idle_off || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_access = access_queue.pop_front();
                    s_tdata <= {4'b0, next_access.reply_byte, next_access.write_data,
                                next_access.reg_offset};
                    s_tuser <= next_access.action;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= idle_off || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        access_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_result = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result transaction 0x%0h arrived with nothing expected", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("read_data", want_result.read_data, seen_result.read_data);
                    check_field("irq_line", 8'(want_result.irq_line), 8'(seen_result.irq_line));
                    check_field("xfer_valid", 8'(want_result.xfer_valid),
                                8'(seen_result.xfer_valid));
                    check_field("tx_byte", want_result.tx_byte, seen_result.tx_byte);
                    check_field("xfer_channel", 8'(want_result.xfer_channel),
                                8'(seen_result.xfer_channel));
                    check_field("cs_release", 8'(want_result.cs_release),
                                8'(seen_result.cs_release));
                    check_field("released_channel", 8'(want_result.released_channel),
                                8'(seen_result.released_channel));
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen_access.action = action_t'(s_tuser);
                seen_access.reg_offset = s_tdata[11:0];
                seen_access.write_data = s_tdata[43:12];
                seen_access.reply_byte = s_tdata[51:44];
                expected_results.push_back(predict_access(seen_access));
                accesses_sent++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timed out with %0d results outstanding.", expected_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic add_access(input action_t act, input logic [11:0] offset,
                              input logic [31:0] wdata, input logic [7:0] reply);
        item_t acc;
        acc.action = act;
        acc.reg_offset = offset;
        acc.write_data = wdata;
        acc.reply_byte = reply;
        access_queue.push_back(acc);
    endtask

    task automatic write_mask(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        dev_mask = value;
        mask_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (access_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic add_random_accesses(input int count);
        action_t     act;
        logic [11:0] offset;
        logic [31:0] wdata;
        for (int i = 0; i < count; i++)
        begin
            act = action_t'($urandom_range(1));
            if ($urandom_range(99) < 88)
                offset = 12'($urandom_range(3) * 4);
            else
                offset = 12'($urandom_range(4095));
            case ($urandom_range(9))
                0: wdata = 32'h0;
                1: wdata = 32'hFFFF_FFFF;
                default: wdata = $urandom;
            endcase
            add_access(act, offset, wdata, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        ctrl_reg = '0;
        cs_reg = '0;
        status_reg = 5'h02;
        rx_reg = '0;
        dev_mask = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_mask(4'b0101);
        add_access(ACT_READ,  OFF_CTRL, 32'hFFFF_FFFF, 8'hFF);
        add_access(ACT_READ,  OFF_STAT, 32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_CTRL, 32'hFFFF_FFFF, 8'h00);
        add_access(ACT_READ,  OFF_CTRL, 32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_DATA, 32'hFFFF_FFA5, 8'h3C);
        add_access(ACT_WRITE, OFF_DATA, 32'h0000_0012, 8'h99);
        add_access(ACT_READ,  OFF_STAT, 32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_STAT, 32'hFFFF_FFEF, 8'h00);
        add_access(ACT_READ,  OFF_STAT, 32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_STAT, 32'h0000_0010, 8'h00);
        add_access(ACT_READ,  OFF_DATA, 32'h0, 8'h00);
        add_access(ACT_READ,  OFF_DATA, 32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_CS,   32'h0000_0000, 8'h00);
        add_access(ACT_WRITE, OFF_CS,   32'hFFFF_FFFD, 8'h00);
        add_access(ACT_WRITE, OFF_DATA, 32'h0000_0000, 8'hFF);
        add_access(ACT_READ,  OFF_DATA, 32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_CS,   32'h0000_0002, 8'h00);
        add_access(ACT_WRITE, OFF_DATA, 32'h0000_007E, 8'h81);
        add_access(ACT_READ,  OFF_DATA, 32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_CS,   32'h0000_0003, 8'h00);
        add_access(ACT_READ,  12'h001,  32'h0, 8'h00);
        add_access(ACT_WRITE, 12'h00D,  32'hFFFF_FFFF, 8'hFF);
        add_access(ACT_WRITE, 12'hFFF,  32'hFFFF_FFFF, 8'hFF);
        add_access(ACT_READ,  12'hFFF,  32'h0, 8'h00);
        add_access(ACT_WRITE, OFF_CTRL, 32'h0000_0000, 8'h00);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_mask(4'hF);
                1: write_mask(4'h0);
                2: write_mask(4'hA);
                default: write_mask(4'($urandom_range(15)));
            endcase
            idle_off = (phase == 2);
            add_random_accesses(PHASE_ITEMS);
            drain();
        end
        idle_off = 1'b0;

        $display("Checked %0d results from %0d register accesses across %0d device mask settings.",
                 results_checked, accesses_sent, mask_writes);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/spimrb_pkg.sv
hdl/spimrb_core.sv
hdl/spi_master_register_block.sv
tb/sv/tb_spi_master_register_block.sv
